// File: rtl/rmn_pkg.sv
package rmn_pkg;

	// default number of samples one run may hold
	localparam int RUN_DEPTH_DEF = 32;

	// field widths
	localparam int DATA_W = 16;
	localparam int KEY_W  = 16;
	localparam int Q_W    = 16;
	localparam int FRAC_W = 12;

	// sized for the largest run the design supports
	localparam int CNT_W  = 6;
	localparam int SUM_W  = 21;
	localparam int PROD_W = DATA_W + CNT_W;
	localparam int REM_W  = SUM_W + 1;

	// run descriptors waiting between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic              bank;
		logic [CNT_W-1:0]  count;
		logic [SUM_W-1:0]  sum;
		logic [KEY_W-1:0]  angle;
		logic              enable;
	} run_desc_t;

	typedef struct packed {
		logic      valid;
		run_desc_t desc;
	} run_push_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} bank_release_t;

endpackage

// File: rtl/ring_mean_normalizer.sv
// a run closes from the hold register once its bank is free and the queue has room; on a key
// change with end of data the old run closes first, then the new one. With the back end idle
// a result passes ST_READ, ST_LOAD, ST_PREP if normalizing a nonzero sum, ST_DIV unless it
// saturates, and is valid in ST_OUT; the next sample is read once it transfers. The front takes
// a sample per cycle while its bank is free, the queue has room and no key change closes a run
// reset: arst_n clears all control state, normalize_enable comes up as 1
module ring_mean_normalizer #(
	parameter int RUN_DEPTH = rmn_pkg::RUN_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration write
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,
	// sample input
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rmn_pkg::DATA_W-1:0]   sample_value,
	input  logic [rmn_pkg::KEY_W-1:0]    angle_key,
	input  logic                         end_of_data,
	// normalized output
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rmn_pkg::Q_W-1:0]      out_value,
	output logic [rmn_pkg::KEY_W-1:0]    out_angle,
	output logic                         run_last,
	output logic                         zero_sum_error
);

	// run index bits, plus one bank select bit for the double buffer
	localparam int IDX_W     = $clog2(RUN_DEPTH);
	localparam int RAM_DEPTH = 2 ** (IDX_W + 1);

	logic                         normalize_enable_q;

	logic                         ram_we;
	logic [IDX_W:0]               ram_waddr;
	logic [rmn_pkg::DATA_W-1:0]   ram_wdata;
	logic                         ram_re;
	logic [IDX_W:0]               ram_raddr;
	logic [rmn_pkg::DATA_W-1:0]   ram_rdata;

	rmn_pkg::run_push_t           push;
	rmn_pkg::run_desc_t           head;
	logic                         q_empty;
	logic                         q_full;
	logic                         pop;
	rmn_pkg::bank_release_t       release_bank;

	// the register value at run close travels with the run descriptor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normalize_enable_q <= 1'b1;
		end else if (cfg_we) begin
			normalize_enable_q <= cfg_wdata;
		end
	end

	// two banks of run storage: front fills one while back drains the other
	rmn_ram #(
		.WIDTH (rmn_pkg::DATA_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// front: buffers samples, tracks run sum and count, closes runs
	rmn_front #(
		.RUN_DEPTH (RUN_DEPTH),
		.IDX_W     (IDX_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.enable       (normalize_enable_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_value (sample_value),
		.angle_key    (angle_key),
		.end_of_data  (end_of_data),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.push         (push),
		.q_full       (q_full),
		.release_bank (release_bank)
	);

	// closed runs waiting for the back end
	rmn_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.empty  (q_empty),
		.full   (q_full)
	);

	// back: reads each run sample, divides by the mean if enabled, holds one result for transfer
	rmn_back #(
		.RUN_DEPTH (RUN_DEPTH),
		.IDX_W     (IDX_W)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.q_empty        (q_empty),
		.pop            (pop),
		.ram_re         (ram_re),
		.ram_raddr      (ram_raddr),
		.ram_rdata      (ram_rdata),
		.release_bank   (release_bank),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_value      (out_value),
		.out_angle      (out_angle),
		.run_last       (run_last),
		.zero_sum_error (zero_sum_error)
	);

endmodule

// File: rtl/rmn_ram.sv
module rmn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/rmn_queue.sv
module rmn_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  rmn_pkg::run_push_t push,
	input  logic               pop,
	output rmn_pkg::run_desc_t head,
	output logic               empty,
	output logic               full
);

	localparam int PTR_W = (rmn_pkg::QUEUE_DEPTH > 1) ? $clog2(rmn_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(rmn_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(rmn_pkg::QUEUE_DEPTH - 1);

	rmn_pkg::run_desc_t entry_q [rmn_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign do_push = push.valid && !full;
	assign do_pop  = pop && !empty;
	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CNT_QW'(rmn_pkg::QUEUE_DEPTH));
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.desc;
		end
	end

endmodule

// File: rtl/rmn_front.sv
module rmn_front #(
	parameter int RUN_DEPTH = rmn_pkg::RUN_DEPTH_DEF,
	parameter int IDX_W     = $clog2(RUN_DEPTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         enable,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rmn_pkg::DATA_W-1:0]   sample_value,
	input  logic [rmn_pkg::KEY_W-1:0]    angle_key,
	input  logic                         end_of_data,
	output logic                         ram_we,
	output logic [IDX_W:0]               ram_waddr,
	output logic [rmn_pkg::DATA_W-1:0]   ram_wdata,
	output rmn_pkg::run_push_t           push,
	input  logic                         q_full,
	input  rmn_pkg::bank_release_t       release_bank
);

	logic                         hold_q;
	logic [rmn_pkg::DATA_W-1:0]   hvalue_q;
	logic [rmn_pkg::KEY_W-1:0]    hkey_q;
	logic                         heod_q;
	logic                         bank_q;
	logic [rmn_pkg::CNT_W-1:0]    count_q;
	logic [rmn_pkg::SUM_W-1:0]    sum_q;
	logic [rmn_pkg::KEY_W-1:0]    angle_q;
	logic [1:0]                   busy_q;

	logic                         key_change;
	logic                         can_go;
	logic                         close_old;
	logic                         do_append;
	logic                         close_new;
	logic [rmn_pkg::CNT_W-1:0]    new_count;
	logic [rmn_pkg::SUM_W-1:0]    new_sum;
	logic [rmn_pkg::KEY_W-1:0]    new_angle;
	logic                         accept;

	assign key_change = (count_q != '0) && (hkey_q != angle_q);
	assign can_go     = hold_q && !busy_q[bank_q] && !q_full;
	assign close_old  = can_go && key_change;
	assign do_append  = can_go && !key_change;
	assign new_count  = count_q + 1'b1;
	assign new_sum    = sum_q + rmn_pkg::SUM_W'(hvalue_q);
	assign new_angle  = (count_q == '0) ? hkey_q : angle_q;
	assign close_new  = do_append
		&& (heod_q || (new_count == rmn_pkg::CNT_W'(RUN_DEPTH)));

	assign in_ready = !hold_q || do_append;
	assign accept   = in_valid && in_ready;

	assign ram_we    = do_append;
	assign ram_waddr = {bank_q, count_q[IDX_W-1:0]};
	assign ram_wdata = hvalue_q;

	always_comb begin
		push.valid       = close_old || close_new;
		push.desc.bank   = bank_q;
		push.desc.enable = enable;
		if (close_old) begin
			push.desc.count = count_q;
			push.desc.sum   = sum_q;
			push.desc.angle = angle_q;
		end else begin
			push.desc.count = new_count;
			push.desc.sum   = new_sum;
			push.desc.angle = new_angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= 1'b0;
			bank_q  <= 1'b0;
			count_q <= '0;
			sum_q   <= '0;
			angle_q <= '0;
			busy_q  <= '0;
		end else begin
			if (accept) begin
				hold_q <= 1'b1;
			end else if (do_append) begin
				hold_q <= 1'b0;
			end
			if (close_old || close_new) begin
				bank_q  <= !bank_q;
				count_q <= '0;
				sum_q   <= '0;
			end else if (do_append) begin
				count_q <= new_count;
				sum_q   <= new_sum;
			end
			if (do_append) begin
				angle_q <= new_angle;
			end
			for (int b = 0; b < 2; b++) begin
				if (push.valid && (bank_q == b[0])) begin
					busy_q[b] <= 1'b1;
				end else if (release_bank.valid && (release_bank.bank == b[0])) begin
					busy_q[b] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hvalue_q <= sample_value;
			hkey_q   <= angle_key;
			heod_q   <= end_of_data;
		end
	end

	// descriptors in flight always have their bank marked busy
	assert property (@(posedge clk) disable iff (!arst_n) q_full |-> (&busy_q))
		else $error("queue full while a bank is free");

	assert property (@(posedge clk) disable iff (!arst_n)
		release_bank.valid |-> busy_q[release_bank.bank])
		else $error("release of a bank that holds no run");

	assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |=> busy_q[$past(bank_q)] && (bank_q != $past(bank_q)))
		else $error("closed run did not claim its bank");

	assert property (@(posedge clk) disable iff (!arst_n) ram_we |-> !busy_q[bank_q])
		else $error("write into a bank still being emitted");

endmodule

// File: rtl/rmn_back.sv
module rmn_back #(
	parameter int RUN_DEPTH = rmn_pkg::RUN_DEPTH_DEF,
	parameter int IDX_W     = $clog2(RUN_DEPTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rmn_pkg::run_desc_t           head,
	input  logic                         q_empty,
	output logic                         pop,
	output logic                         ram_re,
	output logic [IDX_W:0]               ram_raddr,
	input  logic [rmn_pkg::DATA_W-1:0]   ram_rdata,
	output rmn_pkg::bank_release_t       release_bank,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rmn_pkg::Q_W-1:0]      out_value,
	output logic [rmn_pkg::KEY_W-1:0]    out_angle,
	output logic                         run_last,
	output logic                         zero_sum_error
);

	localparam int DIV_STEPS = rmn_pkg::Q_W / 2;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam int LOW_W     = rmn_pkg::Q_W - rmn_pkg::FRAC_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_PREP,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                         state_q;
	rmn_pkg::run_desc_t             desc_q;
	logic [rmn_pkg::CNT_W-1:0]      idx_q;
	logic [rmn_pkg::PROD_W-1:0]     prod_q;
	logic [rmn_pkg::REM_W-1:0]      rem_q;
	logic [rmn_pkg::Q_W-1:0]        dsh_q;
	logic [rmn_pkg::Q_W-1:0]        quo_q;
	logic [STEP_W-1:0]              step_q;

	logic                           last;
	logic [rmn_pkg::REM_W-1:0]      divisor;
	logic [rmn_pkg::REM_W-1:0]      r_a;
	logic [rmn_pkg::REM_W-1:0]      r_a2;
	logic [rmn_pkg::REM_W-1:0]      r_b;
	logic [rmn_pkg::REM_W-1:0]      r_b2;
	logic                           ge_a;
	logic                           ge_b;
	logic [rmn_pkg::Q_W-1:0]        quo_next;
	logic [rmn_pkg::PROD_W+3:0]     sat_limit;

	assign last      = ((idx_q + 1'b1) == desc_q.count);
	assign pop       = (state_q == ST_IDLE) && !q_empty;
	assign ram_re    = (state_q == ST_READ);
	assign ram_raddr = {desc_q.bank, idx_q[IDX_W-1:0]};
	assign out_angle = desc_q.angle;

	assign release_bank.valid = (state_q == ST_OUT) && out_ready && last;
	assign release_bank.bank  = desc_q.bank;

	// quotient saturates once sample * count reaches 16 * sum
	assign sat_limit = {(rmn_pkg::PROD_W + 4 - rmn_pkg::SUM_W - LOW_W)'(0), desc_q.sum,
		LOW_W'(0)};

	// two restoring division steps per cycle
	always_comb begin
		divisor  = rmn_pkg::REM_W'(desc_q.sum);
		r_a      = {rem_q[rmn_pkg::REM_W-2:0], dsh_q[rmn_pkg::Q_W-1]};
		ge_a     = (r_a >= divisor);
		r_a2     = ge_a ? (r_a - divisor) : r_a;
		r_b      = {r_a2[rmn_pkg::REM_W-2:0], dsh_q[rmn_pkg::Q_W-2]};
		ge_b     = (r_b >= divisor);
		r_b2     = ge_b ? (r_b - divisor) : r_b;
		quo_next = {quo_q[rmn_pkg::Q_W-3:0], ge_a, ge_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			out_valid      <= 1'b0;
			out_value      <= '0;
			run_last       <= 1'b0;
			zero_sum_error <= 1'b0;
			idx_q          <= '0;
			step_q         <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						idx_q   <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					run_last <= last;
					if (!desc_q.enable) begin
						out_value      <= ram_rdata;
						zero_sum_error <= 1'b0;
						out_valid      <= 1'b1;
						state_q        <= ST_OUT;
					end else if (desc_q.sum == '0) begin
						out_value      <= '0;
						zero_sum_error <= 1'b1;
						out_valid      <= 1'b1;
						state_q        <= ST_OUT;
					end else begin
						zero_sum_error <= 1'b0;
						state_q        <= ST_PREP;
					end
				end
				ST_PREP: begin
					step_q    <= '0;
					out_value <= '1;
					if ({4'b0, prod_q} >= sat_limit) begin
						out_valid <= 1'b1;
						state_q   <= ST_OUT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q    <= step_q + 1'b1;
					out_value <= quo_next;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						out_valid <= 1'b1;
						state_q   <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					desc_q <= head;
				end
			end
			ST_LOAD: begin
				prod_q <= rmn_pkg::PROD_W'(ram_rdata) * rmn_pkg::PROD_W'(desc_q.count);
			end
			ST_PREP: begin
				rem_q <= rmn_pkg::REM_W'(prod_q >> LOW_W);
				dsh_q <= {prod_q[LOW_W-1:0], rmn_pkg::FRAC_W'(0)};
				quo_q <= '0;
			end
			ST_DIV: begin
				rem_q <= r_b2;
				dsh_q <= {dsh_q[rmn_pkg::Q_W-3:0], 2'b00};
				quo_q <= quo_next;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: dv/ring_mean_normalizer_checker.sv
module ring_mean_normalizer_checker #(
	parameter int RUN_DEPTH = rmn_pkg::RUN_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_wdata,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [rmn_pkg::DATA_W-1:0] sample_value,
	input  logic [rmn_pkg::KEY_W-1:0]  angle_key,
	input  logic                       end_of_data,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [rmn_pkg::Q_W-1:0]    out_value,
	input  logic [rmn_pkg::KEY_W-1:0]  out_angle,
	input  logic                       run_last,
	input  logic                       zero_sum_error,
	output int                         mismatches,
	output int                         awaited,
	output int                         checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [rmn_pkg::Q_W-1:0]   value;
		logic [rmn_pkg::KEY_W-1:0] angle;
		logic                      last;
		logic                      zero_sum;
	} norm_result_t;

	norm_result_t               norm_due[$];
	logic [rmn_pkg::DATA_W-1:0] run_samples [RUN_DEPTH];
	logic [rmn_pkg::SUM_W-1:0]  run_total;
	logic [rmn_pkg::CNT_W-1:0]  run_len;
	logic [rmn_pkg::KEY_W-1:0]  run_key;
	logic                       norm_on;
	int                         fails = 0;
	int                         seen = 0;

	// queue each sample of the open run, mean-scaled if enabled, then empty the run
	task automatic close_run();
		norm_result_t r;
		logic [63:0]  ratio;
		for (int i = 0; i < run_len; i++) begin
			r.angle    = run_key;
			r.last     = (i + 1 == run_len);
			r.zero_sum = 1'b0;
			if (!norm_on) begin
				r.value = run_samples[i];
			end else if (run_total == '0) begin
				r.value    = '0;
				r.zero_sum = 1'b1;
			end else begin
				ratio   = (64'(run_samples[i]) * run_len * 64'(1 << rmn_pkg::FRAC_W))
					/ run_total;
				r.value = (ratio > 64'hFFFF) ? '1 : ratio[rmn_pkg::Q_W-1:0];
			end
			norm_due.insert(norm_due.size(), r);
		end
		run_len   = '0;
		run_total = '0;
	endtask

	task automatic absorb_sample(input logic [rmn_pkg::DATA_W-1:0] s,
			input logic [rmn_pkg::KEY_W-1:0] k, input logic eod);
		if (run_len != 0 && k != run_key)
			close_run();
		if (run_len == 0)
			run_key = k;
		run_samples[run_len] = s;
		run_len++;
		run_total = run_total + rmn_pkg::SUM_W'(s);
		if (eod || run_len >= RUN_DEPTH)
			close_run();
	endtask

	always @(posedge clk or negedge arst_n) begin
		norm_result_t want;
		if (!arst_n) begin
			norm_due.delete();
			run_total = '0;
			run_len   = '0;
			run_key   = '0;
			norm_on   = 1'b1;
		end else begin
			if (cfg_we)
				norm_on = cfg_wdata;
			if (out_valid && out_ready) begin
				if (norm_due.size() == 0) begin
					fails++;
					$error("unexpected output transfer: out_value %0d out_angle %0h",
						out_value, out_angle);
				end else begin
					want = norm_due.pop_front();
					seen++;
					if (out_value !== want.value) begin
						fails++;
						$error("out_value: expected %0d, got %0d", want.value, out_value);
					end
					if (out_angle !== want.angle) begin
						fails++;
						$error("out_angle: expected %0h, got %0h", want.angle, out_angle);
					end
					if (run_last !== want.last) begin
						fails++;
						$error("run_last: expected %0b, got %0b", want.last, run_last);
					end
					if (zero_sum_error !== want.zero_sum) begin
						fails++;
						$error("zero_sum_error: expected %0b, got %0b", want.zero_sum,
							zero_sum_error);
					end
				end
			end
			if (in_valid && in_ready)
				absorb_sample(sample_value, angle_key, end_of_data);
		end
		mismatches <= fails;
		awaited    <= norm_due.size();
		checked    <= seen;
	end

endmodule

// File: dv/ring_mean_normalizer_test.sv
module ring_mean_normalizer_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOTAL_ITEMS   = 450;
	localparam int DIRECTED      = 25;
	localparam int PHASES        = 5;
	localparam int HOLD_PHASE    = 2;
	localparam int RUN_MAX       = rmn_pkg::RUN_DEPTH_DEF;
	// long receiver hold-off, long enough to fill both run banks and the descriptor queue
	localparam int HOLD_CYCLES   = 500;
	// idle cycles after the last result before a register write, covers a sample in flight
	localparam int SETTLE_CYCLES = 24;
	localparam int TAIL_CYCLES   = 40;

	// shapes of the sample values inside one generated run
	typedef enum logic [2:0] {
		SHAPE_ANY,
		SHAPE_ZERO,
		SHAPE_SPIKE,
		SHAPE_FLAT,
		SHAPE_LOW
	} run_shape_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic                       cfg_wdata = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [rmn_pkg::DATA_W-1:0] sample_value = '0;
	logic [rmn_pkg::KEY_W-1:0]  angle_key = '0;
	logic                       end_of_data = 1'b0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [rmn_pkg::Q_W-1:0]    out_value;
	logic [rmn_pkg::KEY_W-1:0]  out_angle;
	logic                       run_last;
	logic                       zero_sum_error;

	int mismatches;
	int awaited;
	int checked;

	int                        items_sent = 0;
	int                        runs_sent = 0;
	int                        cfg_writes = 0;
	int                        burst_left = 0;
	int                        hold_asked = 0;
	bit                        eager = 1'b0;
	logic [rmn_pkg::KEY_W-1:0] last_key = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ring_mean_normalizer u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample_value   (sample_value),
		.angle_key      (angle_key),
		.end_of_data    (end_of_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_value      (out_value),
		.out_angle      (out_angle),
		.run_last       (run_last),
		.zero_sum_error (zero_sum_error)
	);

	ring_mean_normalizer_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample_value   (sample_value),
		.angle_key      (angle_key),
		.end_of_data    (end_of_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_value      (out_value),
		.out_angle      (out_angle),
		.run_last       (run_last),
		.zero_sum_error (zero_sum_error),
		.mismatches     (mismatches),
		.awaited        (awaited),
		.checked        (checked)
	);

	// offer one sample and hold it until the transfer; valid stays up inside a burst
	task automatic push_sample(input logic [rmn_pkg::DATA_W-1:0] v,
			input logic [rmn_pkg::KEY_W-1:0] k, input logic eod);
		in_valid     <= 1'b1;
		sample_value <= v;
		angle_key    <= k;
		end_of_data  <= eod;
		last_key      = k;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		if (eager || burst_left > 0) begin
			if (burst_left > 0)
				burst_left--;
		end else begin
			// burst over: drop valid for a random gap, then pick the next burst length
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(posedge clk);
			burst_left = $urandom_range(0, 12);
		end
	endtask

	// stop offering and wait for every predicted result to come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0)
			@(posedge clk);
	endtask

	// register write only with the block idle; an open run may stay buffered across it
	task automatic reconfigure(input logic enable);
		wait_drained();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= enable;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_writes++;
	endtask

	// receiver: stall pattern of its own, picked anew for each random-length segment,
	// plus one long hold-off on request from the stimulus
	initial begin
		int          holds_done;
		int          seg_left;
		int          pos;
		logic [15:0] pattern;
		holds_done = 0;
		seg_left   = 0;
		pos        = 0;
		pattern    = '1;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_asked != holds_done) begin
				holds_done++;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
			end else begin
				if (seg_left == 0) begin
					case ($urandom_range(0, 3))
						0: pattern = '1;                         // never stalls
						1: pattern = 16'($urandom);              // even mix
						2: pattern = 16'($urandom & $urandom);   // mostly stalled
						// rare stalls
						default: pattern = ~16'($urandom & $urandom & $urandom);
					endcase
					seg_left = $urandom_range(16, 96);
				end
				out_ready <= pattern[pos % 16];
				pos++;
				seg_left--;
			end
		end
	end

	initial begin
		#5ms;
		$display("FAIL ring_mean_normalizer");
		$finish;
	end

	initial begin
		run_shape_t                 shape;
		int                         len;
		int                         pick;
		int                         phase_end;
		logic [rmn_pkg::KEY_W-1:0]  key;
		logic [rmn_pkg::DATA_W-1:0] level;
		logic [rmn_pkg::DATA_W-1:0] v;
		bit                         flush;

		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		// directed part, normalization on from reset
		// single-sample run at full scale flushed by end of data
		push_sample(16'hFFFF, 16'hFFFF, 1'b1);
		// zero-sum run on key zero
		push_sample(16'h0000, 16'h0000, 1'b0);
		push_sample(16'h0000, 16'h0000, 1'b0);
		// a spike over zeros: the key change closes the zero-sum run, the spike saturates
		for (int i = 0; i < 16; i++)
			push_sample((i == 0) ? 16'hFFFF : 16'h0000, 16'h8000, 1'b0);
		// key change together with end of data: two runs close on one sample
		push_sample(16'h0001, 16'h7FFF, 1'b1);

		// pass-through, including a zero-sum run that must not flag
		reconfigure(1'b0);
		push_sample(16'h1234, 16'h00FF, 1'b0);
		push_sample(16'hEDCB, 16'h00FF, 1'b0);
		push_sample(16'h0000, 16'h0F0F, 1'b1);

		// enable flips while a run is open: the setting at close time applies
		push_sample(16'd100, 16'h0AAA, 1'b0);
		reconfigure(1'b1);
		push_sample(16'd200, 16'h0AAA, 1'b1);

		// random phases, each under its own setting; the open run carries over
		for (int p = 0; p < PHASES; p++) begin
			reconfigure((p == 0) ? 1'b1 : (p == 1) ? 1'b0 : 1'($urandom_range(0, 1)));
			phase_end = DIRECTED + (TOTAL_ITEMS - DIRECTED) * (p + 1) / PHASES;
			if (p == HOLD_PHASE) begin
				// back-to-back input while the receiver holds off
				eager = 1'b1;
				hold_asked++;
			end
			while (items_sent < phase_end) begin
				if (p == HOLD_PHASE && items_sent >= phase_end - 15)
					eager = 1'b0;
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					// noise: lone sample with any key and any end mark
					push_sample(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
				end else begin
					key = ($urandom_range(0, 9) == 0) ? last_key : 16'($urandom);
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5: len = $urandom_range(1, 6);
						6, 7, 8:          len = $urandom_range(7, 31);
						default:          len = $urandom_range(RUN_MAX, RUN_MAX + 1);
					endcase
					shape = run_shape_t'($urandom_range(0, 4));
					flush = ($urandom_range(0, 2) == 0);
					level = 16'($urandom);
					for (int i = 0; i < len; i++) begin
						case (shape)
							SHAPE_ZERO:  v = '0;
							SHAPE_SPIKE: v = (i == 0) ? 16'($urandom_range(49152, 65535))
								: 16'($urandom_range(0, 3));
							SHAPE_FLAT:  v = level;
							SHAPE_LOW:   v = 16'($urandom_range(0, 15));
							default:     v = 16'($urandom);
						endcase
						push_sample(v, key, flush && i == len - 1);
					end
					runs_sent++;
					// now and then the sender pauses until the output side has caught up
					if (pick >= 96)
						wait_drained();
				end
			end
		end

		// flush whatever run is still open
		push_sample(16'($urandom), last_key, 1'b1);
		wait_drained();
		repeat (TAIL_CYCLES)
			@(posedge clk);

		$display("covered %0d samples (%0d generated runs after %0d directed)",
			items_sent, runs_sent, DIRECTED);
		$display("%0d results compared, normalize_enable written %0d times, %0d-cycle hold-off",
			checked, cfg_writes, HOLD_CYCLES);
		if (mismatches == 0 && awaited == 0) begin
			$display("PASS ring_mean_normalizer");
		end else begin
			$display("FAIL ring_mean_normalizer");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/rmn_pkg.sv
rtl/rmn_ram.sv
rtl/rmn_queue.sv
rtl/rmn_front.sv
rtl/rmn_back.sv
rtl/ring_mean_normalizer.sv
dv/ring_mean_normalizer_checker.sv
dv/ring_mean_normalizer_test.sv
